@@ rtl/lca_pkg.sv @@
package lca_pkg;

   localparam int NUM_CONTEXTS = 8;
   localparam int OWNER_BITS   = 16;
   localparam int STAMP_BITS   = 32;

   // Widths of the request and result fields.
   localparam int CTX_BITS    = 3;
   localparam int OWNER_FIELD = 16;
   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 2;

   localparam int IDX_BITS = $clog2(NUM_CONTEXTS);
   localparam int CMP_BITS = (IDX_BITS > CTX_BITS) ? IDX_BITS : CTX_BITS;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_TOUCH = 2'd1,
      MODE_FREE  = 2'd2,
      MODE_PASS  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_RESERVED = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic commit_alloc;
      logic exec_other;
   } dp_cmd_type;

   typedef struct packed {
      logic in_alloc;
      logic scan_done;
   } dp_status_type;

endpackage

@@ rtl/lca_ctrl.sv @@
module lca_ctrl import lca_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd,
   output logic          busy
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_COMMIT = 4'b0100,
      S_EXEC   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               dp_cmd.load = 1'b1;
               state_in    = dp_status.in_alloc ? S_SCAN : S_EXEC;
            end
         end
         S_SCAN: begin
            dp_cmd.scan_step = 1'b1;
            if (dp_status.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            dp_cmd.commit_alloc = 1'b1;
            state_in            = S_IDLE;
         end
         S_EXEC: begin
            dp_cmd.exec_other = 1'b1;
            state_in          = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ rtl/lca_datapath.sv @@
module lca_datapath import lca_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CTX_BITS-1:0]    csr_write_data,
   input  logic [MODE_BITS-1:0]   req_mode,
   input  logic [OWNER_FIELD-1:0] req_owner,
   input  logic [OWNER_FIELD-1:0] req_new_owner,
   input  logic [CTX_BITS-1:0]    req_context,
   input  dp_cmd_type             dp_cmd,
   output dp_status_type          dp_status,
   output logic                   rsp_strobe,
   output logic [CTX_BITS-1:0]    rsp_granted_context,
   output logic                   rsp_evicted,
   output logic [OWNER_FIELD-1:0] rsp_evicted_owner,
   output logic [STATUS_BITS-1:0] rsp_status
);

   logic [OWNER_BITS-1:0] owner_ff [NUM_CONTEXTS];
   logic [OWNER_BITS-1:0] owner_in [NUM_CONTEXTS];
   logic [STAMP_BITS-1:0] stamp_ff [NUM_CONTEXTS];
   logic [STAMP_BITS-1:0] stamp_in [NUM_CONTEXTS];
   logic [STAMP_BITS-1:0] counter_ff, counter_in;
   logic [CTX_BITS-1:0]   reserved_ff, reserved_in;

   // Latched request.
   mode_type              mode_ff, mode_in;
   logic [OWNER_BITS-1:0] own_ff, own_in;
   logic [OWNER_BITS-1:0] new_own_ff, new_own_in;
   logic [CTX_BITS-1:0]   ctx_ff, ctx_in;

   // Scan state.
   logic [IDX_BITS-1:0]   scan_idx_ff, scan_idx_in;
   logic [IDX_BITS-1:0]   pick_ff, pick_in;
   logic [OWNER_BITS-1:0] pick_owner_ff, pick_owner_in;
   logic [STAMP_BITS-1:0] oldest_ff, oldest_in;
   logic                  have_old_ff, have_old_in;

   // Result registers.
   logic                   strobe_ff, strobe_in;
   logic [CTX_BITS-1:0]    granted_ff, granted_in;
   logic                   evicted_ff, evicted_in;
   logic [OWNER_FIELD-1:0] ev_owner_ff, ev_owner_in;
   status_type             status_ff, status_in;

   logic [IDX_BITS-1:0]   req_idx;
   logic [IDX_BITS-1:0]   rd_idx;
   logic [OWNER_BITS-1:0] owner_rd;
   logic [STAMP_BITS-1:0] stamp_rd;
   logic                  skip, free_hit, older, last_idx, req_bad;

   assign req_idx  = IDX_BITS'(ctx_ff);
   assign rd_idx   = dp_cmd.scan_step ? scan_idx_ff : req_idx;
   assign owner_rd = owner_ff[rd_idx];
   assign stamp_rd = stamp_ff[rd_idx];

   assign skip     = (CMP_BITS'(scan_idx_ff) == CMP_BITS'(reserved_ff));
   assign free_hit = !skip && (owner_rd == '0);
   assign older    = !skip && (owner_rd != '0) && (!have_old_ff || (stamp_rd <= oldest_ff));
   assign last_idx = (scan_idx_ff == IDX_BITS'(NUM_CONTEXTS - 1));
   assign req_bad  = (32'(ctx_ff) >= NUM_CONTEXTS) || (ctx_ff == reserved_ff);

   assign dp_status.in_alloc  = (mode_type'(req_mode) == MODE_ALLOC);
   assign dp_status.scan_done = free_hit || last_idx;

   always_comb begin
      owner_in      = owner_ff;
      stamp_in      = stamp_ff;
      counter_in    = counter_ff;
      reserved_in   = csr_write_enable ? csr_write_data : reserved_ff;
      mode_in       = mode_ff;
      own_in        = own_ff;
      new_own_in    = new_own_ff;
      ctx_in        = ctx_ff;
      scan_idx_in   = scan_idx_ff;
      pick_in       = pick_ff;
      pick_owner_in = pick_owner_ff;
      oldest_in     = oldest_ff;
      have_old_in   = have_old_ff;
      strobe_in     = 1'b0;
      granted_in    = granted_ff;
      evicted_in    = evicted_ff;
      ev_owner_in   = ev_owner_ff;
      status_in     = status_ff;

      if (dp_cmd.load) begin
         mode_in     = mode_type'(req_mode);
         own_in      = OWNER_BITS'(req_owner);
         new_own_in  = OWNER_BITS'(req_new_owner);
         ctx_in      = req_context;
         scan_idx_in = '0;
         have_old_in = 1'b0;
      end

      if (dp_cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + 1'b1;
         if (free_hit) begin
            pick_in       = scan_idx_ff;
            pick_owner_in = '0;
         end else if (older) begin
            pick_in       = scan_idx_ff;
            pick_owner_in = owner_rd;
            oldest_in     = stamp_rd;
            have_old_in   = 1'b1;
         end
      end

      if (dp_cmd.commit_alloc) begin
         owner_in[pick_ff] = own_ff;
         stamp_in[pick_ff] = counter_ff;
         counter_in        = counter_ff + 1'b1;
         strobe_in         = 1'b1;
         granted_in        = CTX_BITS'(pick_ff);
         evicted_in        = (pick_owner_ff != '0);
         ev_owner_in       = OWNER_FIELD'(pick_owner_ff);
         status_in         = STATUS_OK;
      end

      if (dp_cmd.exec_other) begin
         strobe_in   = 1'b1;
         granted_in  = ctx_ff;
         evicted_in  = 1'b0;
         ev_owner_in = '0;
         status_in   = STATUS_OK;
         if (req_bad) begin
            status_in = STATUS_RESERVED;
         end else begin
            unique case (mode_ff)
               MODE_TOUCH: begin
                  stamp_in[req_idx] = counter_ff;
                  counter_in        = counter_ff + 1'b1;
               end
               MODE_FREE: begin
                  if (owner_rd != own_ff) begin
                     status_in = STATUS_MISMATCH;
                  end else begin
                     owner_in[req_idx] = '0;
                  end
               end
               MODE_PASS: owner_in[req_idx] = new_own_ff;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CONTEXTS; i++) begin
            owner_ff[i] <= '0;
            stamp_ff[i] <= '0;
         end
         counter_ff  <= '0;
         reserved_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         owner_ff    <= owner_in;
         stamp_ff    <= stamp_in;
         counter_ff  <= counter_in;
         reserved_ff <= reserved_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      own_ff        <= own_in;
      new_own_ff    <= new_own_in;
      ctx_ff        <= ctx_in;
      scan_idx_ff   <= scan_idx_in;
      pick_ff       <= pick_in;
      pick_owner_ff <= pick_owner_in;
      oldest_ff     <= oldest_in;
      have_old_ff   <= have_old_in;
      granted_ff    <= granted_in;
      evicted_ff    <= evicted_in;
      ev_owner_ff   <= ev_owner_in;
      status_ff     <= status_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_granted_context = granted_ff;
   assign rsp_evicted         = evicted_ff;
   assign rsp_evicted_owner   = ev_owner_ff;
   assign rsp_status          = status_ff;

endmodule

@@ rtl/lru_context_allocator_unit.sv @@
// Channel    Ports                                         Handshake
// request    req_mode req_owner req_new_owner req_context  start high, busy low
// response   rsp_granted_context rsp_evicted ...           rsp_strobe, one cycle
// csr        csr_write_data                                csr_write_enable
//
// An allocate request walks the context table one entry per cycle and stops
// early at the first free context, then commits; touch, free and pass skip
// the scan and go straight to the execute state before their response.
// Synchronous reset frees every context and clears all stamps and the counter.
// The receiver cannot stall; busy is low again when the response is shown.
module lru_context_allocator_unit import lca_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [MODE_BITS-1:0]   req_mode,
   input  logic [OWNER_FIELD-1:0] req_owner,
   input  logic [OWNER_FIELD-1:0] req_new_owner,
   input  logic [CTX_BITS-1:0]    req_context,
   output logic                   rsp_strobe,
   output logic [CTX_BITS-1:0]    rsp_granted_context,
   output logic                   rsp_evicted,
   output logic [OWNER_FIELD-1:0] rsp_evicted_owner,
   output logic [STATUS_BITS-1:0] rsp_status,
   input  logic                   csr_write_enable,
   input  logic [CTX_BITS-1:0]    csr_write_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   lca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd),
      .busy      (busy)
   );

   lca_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_mode            (req_mode),
      .req_owner           (req_owner),
      .req_new_owner       (req_new_owner),
      .req_context         (req_context),
      .dp_cmd              (dp_cmd),
      .dp_status           (dp_status),
      .rsp_strobe          (rsp_strobe),
      .rsp_granted_context (rsp_granted_context),
      .rsp_evicted         (rsp_evicted),
      .rsp_evicted_owner   (rsp_evicted_owner),
      .rsp_status          (rsp_status)
   );

   // A response always comes after the controller has returned to idle.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("response shown while a request is in progress");

   // An accepted request makes the unit busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   // An eviction always names the owner that lost the context.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_evicted) |-> (rsp_evicted_owner != '0))
      else $error("eviction reported with no owner");

   // Only a successful allocate can evict.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |-> !rsp_evicted)
      else $error("eviction reported on a failed request");

endmodule
